FILE: hw/rtl/tat_pkg.sv
`default_nettype none
package tat_pkg;

   localparam int MaxTracks  = 16;
   localparam int SlotBits   = 4;
   localparam int CountBits  = 5;
   localparam int CoordBits  = 12;
   localparam int DistBits   = 27;
   localparam int TotalBits  = 16;
   localparam int MissBits   = 6;
   localparam int LookBits   = 4;

   localparam logic [TotalBits-1:0] TOTAL_MAX = '1;
   localparam logic [MissBits-1:0]  MISS_MAX  = '1;
   localparam logic [LookBits-1:0]  LOOK_MAX  = '1;
   localparam logic [4:0]           MISS_LIMIT_RESET = 5'd10;
   localparam logic [2:0]           LOOK_LIMIT_RESET = 3'd2;

   localparam logic [1:0] KIND_DETECT = 2'd0;
   localparam logic [1:0] KIND_UPDATE = 2'd1;
   localparam logic [1:0] KIND_FRAME  = 2'd2;

   localparam logic [2:0] ST_MATCHED = 3'd0;
   localparam logic [2:0] ST_NEW     = 3'd1;
   localparam logic [2:0] ST_FULL    = 3'd2;
   localparam logic [2:0] ST_UPDATED = 3'd3;
   localparam logic [2:0] ST_FRAME   = 3'd4;
   localparam logic [2:0] ST_BADSLOT = 3'd5;

   localparam logic CSR_MISS_LIMIT = 1'b0;
   localparam logic CSR_LOOK_LIMIT = 1'b1;

   typedef struct packed {
      logic [1:0]           kind;
      logic [CoordBits-1:0] box_x;
      logic [CoordBits-1:0] box_y;
      logic [CoordBits-1:0] box_w;
      logic [CoordBits-1:0] box_h;
      logic                 has_eye;
      logic [SlotBits-1:0]  slot;
   } req_type;

   typedef struct packed {
      logic [2:0]           status;
      logic [SlotBits-1:0]  track_slot;
      logic [TotalBits-1:0] face_total;
      logic [TotalBits-1:0] focus_total;
      logic [CountBits-1:0] active_tracks;
   } rsp_type;

   typedef struct packed {
      logic [CoordBits-1:0] x;
      logic [CoordBits-1:0] y;
      logic [CoordBits-1:0] w;
      logic [CoordBits-1:0] h;
   } box_type;

   typedef struct packed {
      box_type             box;
      logic [MissBits-1:0] miss;
      logic [LookBits-1:0] look;
      logic                focused;
   } entry_type;

   // memory port bundle from the sequencer
   typedef struct packed {
      logic                rd_en;
      logic [SlotBits-1:0] rd_addr;
      logic                wr_en;
      logic [SlotBits-1:0] wr_addr;
      entry_type           wr_data;
   } mem_ctl_type;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_DECIDE, S_AGE, S_RESULT
   } state_type;

   function automatic logic [CoordBits:0] center(input logic [CoordBits-1:0] p,
                                                 input logic [CoordBits-1:0] s);
      center = {1'b0, p} + {2'b00, s[CoordBits-1:1]};
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/tat_table_ram.sv
`default_nettype none
module tat_table_ram #(
   parameter int Depth = 16,
   parameter int Width = 8
) (
   input  wire logic                     clock,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

FILE: hw/rtl/tat_dist.sv
`default_nettype none
module tat_dist (
   input  wire logic                            clock,
   input  wire tat_pkg::box_type                det_box,
   input  wire tat_pkg::box_type                trk_box,
   output logic [tat_pkg::DistBits-1:0]         dist_ff
);
   import tat_pkg::*;

   logic [CoordBits:0]   dcx, dcy, tcx, tcy, ax, ay;
   logic [DistBits-1:0]  dist_in;

   // squared center distance, registered
   always_comb begin
      dcx = center(det_box.x, det_box.w);
      dcy = center(det_box.y, det_box.h);
      tcx = center(trk_box.x, trk_box.w);
      tcy = center(trk_box.y, trk_box.h);
      ax  = (dcx > tcx) ? dcx - tcx : tcx - dcx;
      ay  = (dcy > tcy) ? dcy - tcy : tcy - dcy;
      dist_in = DistBits'({13'd0, ax} * {13'd0, ax}) + DistBits'({13'd0, ay} * {13'd0, ay});
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
   end
endmodule
`default_nettype wire

FILE: hw/rtl/track_association_table.sv
// track association table
//
// req channel: one request per detection (kind 0), tracker box update (kind 1)
// or frame end (kind 2); kind 3 is dropped with no response.
// rsp channel: one response per request of kinds 0 to 2, carrying status, slot and totals.
// csr port: index 0 miss_limit, index 1 look_limit; write only while idle.
//
// detections walk all live entries through the table memory, one entry per
// cycle; each entry passes the memory read register and the distance register
// before the compare, and the decision and response follow the last compare.
// frame end rereads every live entry and writes the kept ones packed down in
// order. updates answer in the cycle after they are taken; a valid slot then
// has its box written back in S_RESULT.
// one request is in work at a time; the memory read port sets the pace.
// a response waits in an output register while rsp_stall is high; the next
// request is taken the cycle after that register has been taken.
// reset is synchronous; it clears counters and seen flags and sets the limits
// back to 10 and 2.
// table entries need no clearing: only entries below the live count are read.
`default_nettype none
module track_association_table (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire tat_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output tat_pkg::rsp_type       rsp_data,
   input  wire logic              csr_write,
   input  wire logic              csr_index,
   input  wire logic [4:0]        csr_data
);
   import tat_pkg::*;

   state_type               state_ff, state_in;
   req_type                 req_ff, req_in;
   logic [4:0]              miss_limit_ff, miss_limit_in;
   logic [2:0]              look_limit_ff, look_limit_in;
   logic [CountBits-1:0]    live_ff, live_in;
   logic [TotalBits-1:0]    opened_ff, opened_in, focused_ff, focused_in;
   logic [MaxTracks-1:0]    seen_ff, seen_in;
   logic [CountBits-1:0]    cnt_ff, cnt_in;       // read pointer
   logic [CountBits-1:0]    wcnt_ff, wcnt_in;     // write pointer for packing
   logic                    pend_ff, pend_in;     // read data valid next cycle
   logic [SlotBits-1:0]     pidx_ff, pidx_in;     // index of read in flight
   logic                    dval_ff, dval_in;     // distance register valid
   logic [SlotBits-1:0]     didx_ff, didx_in;
   entry_type               dent_ff, dent_in;
   logic [DistBits-1:0]     best_ff, best_in;
   logic [SlotBits-1:0]     bidx_ff, bidx_in;
   entry_type               bent_ff, bent_in;
   logic                    found_ff, found_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;
   mem_ctl_type             mc;
   entry_type               rd_data;
   logic [DistBits-1:0]     cand_dist;
   entry_type               aged;
   logic                    last_rd;

   tat_table_ram #(.Depth(MaxTracks), .Width($bits(entry_type))) u_ram (
      .clock   (clock),
      .rd_en   (mc.rd_en),
      .rd_addr (mc.rd_addr),
      .rd_data (rd_data),
      .wr_en   (mc.wr_en),
      .wr_addr (mc.wr_addr),
      .wr_data (mc.wr_data)
   );

   tat_dist u_dist (
      .clock   (clock),
      .det_box ({req_ff.box_x, req_ff.box_y, req_ff.box_w, req_ff.box_h}),
      .trk_box (rd_data.box),
      .dist_ff (cand_dist)
   );

   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         miss_limit_ff <= MISS_LIMIT_RESET;
         look_limit_ff <= LOOK_LIMIT_RESET;
         live_ff       <= '0;
         opened_ff     <= '0;
         focused_ff    <= '0;
         seen_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_ff       <= 1'b0;
         dval_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         miss_limit_ff <= miss_limit_in;
         look_limit_ff <= look_limit_in;
         live_ff       <= live_in;
         opened_ff     <= opened_in;
         focused_ff    <= focused_in;
         seen_ff       <= seen_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_ff       <= pend_in;
         dval_ff       <= dval_in;
      end
      req_ff   <= req_in;
      cnt_ff   <= cnt_in;
      wcnt_ff  <= wcnt_in;
      pidx_ff  <= pidx_in;
      didx_ff  <= didx_in;
      dent_ff  <= dent_in;
      best_ff  <= best_in;
      bidx_ff  <= bidx_in;
      bent_ff  <= bent_in;
      found_ff <= found_in;
      rsp_ff   <= rsp_in;
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      miss_limit_in = miss_limit_ff;
      look_limit_in = look_limit_ff;
      live_in       = live_ff;
      opened_in     = opened_ff;
      focused_in    = focused_ff;
      seen_in       = seen_ff;
      cnt_in        = cnt_ff;
      wcnt_in       = wcnt_ff;
      pend_in       = 1'b0;
      pidx_in       = pidx_ff;
      dval_in       = 1'b0;
      didx_in       = didx_ff;
      dent_in       = dent_ff;
      best_in       = best_ff;
      bidx_in       = bidx_ff;
      bent_in       = bent_ff;
      found_in      = found_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      mc            = '0;
      aged          = rd_data;
      last_rd       = (cnt_ff >= live_ff);

      if (csr_write) begin
         unique case (csr_index)
            CSR_MISS_LIMIT: miss_limit_in = csr_data;
            CSR_LOOK_LIMIT: look_limit_in = csr_data[2:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               req_in   = req_data;
               cnt_in   = '0;
               wcnt_in  = '0;
               found_in = 1'b0;
               best_in  = '1;
               unique case (req_data.kind)
                  KIND_DETECT: state_in = S_SCAN;
                  KIND_FRAME:  state_in = S_AGE;
                  KIND_UPDATE: begin
                     rsp_valid_in         = 1'b1;
                     rsp_in.face_total    = opened_ff;
                     rsp_in.focus_total   = focused_ff;
                     rsp_in.active_tracks = live_ff;
                     if (CountBits'(req_data.slot) < live_ff) begin
                        // box only: read-modify-write of the entry
                        state_in          = S_RESULT;
                        rsp_in.status     = ST_UPDATED;
                        rsp_in.track_slot = req_data.slot;
                        mc.rd_en          = 1'b1;
                        mc.rd_addr        = req_data.slot;
                     end else begin
                        rsp_in.status     = ST_BADSLOT;
                        rsp_in.track_slot = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            // read stream, distance stage, then compare
            if (!last_rd) begin
               mc.rd_en   = 1'b1;
               mc.rd_addr = cnt_ff[SlotBits-1:0];
               pend_in    = 1'b1;
               pidx_in    = cnt_ff[SlotBits-1:0];
               cnt_in     = cnt_ff + 1'b1;
            end
            if (pend_ff) begin
               dval_in = 1'b1;
               didx_in = pidx_ff;
               dent_in = rd_data;
            end
            if (dval_ff && cand_dist < best_ff) begin
               best_in  = cand_dist;
               bidx_in  = didx_ff;
               bent_in  = dent_ff;
               found_in = 1'b1;
            end
            if (last_rd && !pend_ff && !dval_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in             = S_IDLE;
            rsp_valid_in         = 1'b1;
            mc.wr_data.box       = {req_ff.box_x, req_ff.box_y, req_ff.box_w, req_ff.box_h};
            if (found_ff && {3'd0, best_ff} < {18'd0, req_ff.box_w} * {18'd0, req_ff.box_w}) begin
               mc.wr_en              = 1'b1;
               mc.wr_addr            = bidx_ff;
               mc.wr_data.miss       = bent_ff.miss;
               mc.wr_data.look       = bent_ff.look;
               mc.wr_data.focused    = bent_ff.focused;
               seen_in[bidx_ff]      = 1'b1;
               if (req_ff.has_eye && !bent_ff.focused) begin
                  if (bent_ff.look != LOOK_MAX) begin
                     mc.wr_data.look = bent_ff.look + 1'b1;
                  end
                  if (mc.wr_data.look > {1'b0, look_limit_ff}) begin
                     mc.wr_data.focused = 1'b1;
                     if (focused_ff != TOTAL_MAX) begin
                        focused_in = focused_ff + 1'b1;
                     end
                  end
               end
               rsp_in.status     = ST_MATCHED;
               rsp_in.track_slot = bidx_ff;
            end else if (live_ff >= CountBits'(MaxTracks)) begin
               rsp_in.status     = ST_FULL;
               rsp_in.track_slot = '0;
            end else begin
               mc.wr_en           = 1'b1;
               mc.wr_addr         = live_ff[SlotBits-1:0];
               mc.wr_data.miss    = '0;
               mc.wr_data.look    = {{(LookBits-1){1'b0}}, req_ff.has_eye};
               mc.wr_data.focused = 1'b0;
               seen_in[live_ff[SlotBits-1:0]] = 1'b1;
               live_in            = live_ff + 1'b1;
               if (opened_ff != TOTAL_MAX) begin
                  opened_in = opened_ff + 1'b1;
               end
               rsp_in.status     = ST_NEW;
               rsp_in.track_slot = live_ff[SlotBits-1:0];
            end
            rsp_in.face_total    = opened_in;
            rsp_in.focus_total   = focused_in;
            rsp_in.active_tracks = live_in;
         end
         S_AGE: begin
            // age each entry as it returns and pack survivors downward
            if (!last_rd) begin
               mc.rd_en   = 1'b1;
               mc.rd_addr = cnt_ff[SlotBits-1:0];
               pend_in    = 1'b1;
               pidx_in    = cnt_ff[SlotBits-1:0];
               cnt_in     = cnt_ff + 1'b1;
            end
            if (pend_ff) begin
               if (seen_ff[pidx_ff]) begin
                  aged.miss = '0;
               end else if (rd_data.miss != MISS_MAX) begin
                  aged.miss = rd_data.miss + 1'b1;
               end
               if (aged.miss <= {1'b0, miss_limit_ff}) begin
                  mc.wr_en   = 1'b1;
                  mc.wr_addr = wcnt_ff[SlotBits-1:0];
                  mc.wr_data = aged;
                  wcnt_in    = wcnt_ff + 1'b1;
               end
            end
            if (last_rd && !pend_ff) begin
               state_in             = S_IDLE;
               live_in              = wcnt_ff;
               seen_in              = '0;
               rsp_valid_in         = 1'b1;
               rsp_in.status        = ST_FRAME;
               rsp_in.track_slot    = '0;
               rsp_in.face_total    = opened_ff;
               rsp_in.focus_total   = focused_ff;
               rsp_in.active_tracks = wcnt_ff;
            end
         end
         S_RESULT: begin
            // write back the updated box for a tracker request
            state_in       = S_IDLE;
            mc.wr_en       = 1'b1;
            mc.wr_addr     = req_ff.slot;
            mc.wr_data     = rd_data;
            mc.wr_data.box = {req_ff.box_x, req_ff.box_y, req_ff.box_w, req_ff.box_h};
         end
         default: state_in = S_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   // live count never exceeds the table size
   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_ff <= CountBits'(MaxTracks))
      else $error("live count over table size");

   // no new request is taken while a response waits
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> req_stall)
      else $error("request accepted with response pending");

   // a frame end response clears all seen flags
   a_frame_clears_seen: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_AGE && state_in == S_IDLE) |=> (seen_ff == '0))
      else $error("seen flags left after frame end");
`endif
endmodule
`default_nettype wire
